FILE: sv/tensor_permute_address_generator_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the tensor permute address generator
// Clocked implication checks used by the checker file.
// ----------------------------------------------------------------------------
`ifndef TENSOR_PERMUTE_ADDRESS_GENERATOR_MACROS_SVH
`define TENSOR_PERMUTE_ADDRESS_GENERATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TPAG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define TPAG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/tpag_pkg.sv
// ----------------------------------------------------------------------------
// tpag_pkg
// Types, widths and codes shared by the tensor permute address generator.
// ----------------------------------------------------------------------------
package tpag_pkg;

  localparam int ADDR_W       = 60;
  localparam int ELEM_FIELD_W = 64;
  localparam int NUM_DIMS     = 6;
  localparam int RANK_W       = 3;
  localparam int SIZE_W       = 11;
  localparam int PERM_W       = 18;
  localparam int PERM_FIELD_W = 3;
  localparam int CFG_DATA_W   = 18;
  localparam int CFG_IDX_W    = 3;

  localparam int IN_TDATA_W  = ((ELEM_FIELD_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((ADDR_W + ELEM_FIELD_W + 7) / 8) * 8;

  localparam int MAX_RANK_DEF     = 6;
  localparam int DIM_BITS_DEF     = 10;
  localparam int ELEMENT_BITS_DEF = 64;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RANK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERM  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE0 = 3'd2;

  localparam logic [RANK_W-1:0] RESET_RANK = 3'd1;
  localparam logic [PERM_W-1:0] RESET_PERM = 18'd181896;
  localparam logic [SIZE_W-1:0] RESET_SIZE = 11'd1;

  typedef logic [ADDR_W-1:0] addr_t;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_START,
    SEQ_STRIDE,
    SEQ_BACK,
    SEQ_DELTA
  } seq_state_t;

  // Control from the stride sequencer to one cell
  typedef struct packed {
    logic  clear;
    logic  stride_add;
    logic  back_calc;
    logic  delta_load;
    addr_t coef;
    addr_t acc;
  } cell_ctl_t;

endpackage

FILE: sv/tpag_cell.sv
// ----------------------------------------------------------------------------
// tpag_cell
// One source dimension: index counter, stride and precomputed address step.
// ----------------------------------------------------------------------------
module tpag_cell #(
  parameter int DIM_BITS = tpag_pkg::DIM_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tpag_pkg::cell_ctl_t ctl,
  input  logic [DIM_BITS-1:0] top_idx,
  input  logic                active,
  input  logic                carry_in,
  input  logic                step,
  output tpag_pkg::addr_t     back,
  output tpag_pkg::addr_t     delta,
  output logic                carry_out,
  output logic                hit
);
  import tpag_pkg::*;

  logic [DIM_BITS-1:0]        idx_r, idx_nxt;
  addr_t                      stride_r, stride_nxt;
  addr_t                      back_r, delta_r;
  logic [ADDR_W+DIM_BITS-1:0] back_prod;
  logic                       wrap;

  assign wrap      = (idx_r >= top_idx);
  assign carry_out = active ? (carry_in & wrap) : carry_in;
  assign hit       = active & carry_in & ~wrap;
  assign back_prod = stride_r * top_idx;
  assign back      = back_r;
  assign delta     = delta_r;

  always_comb begin
    idx_nxt    = idx_r;
    stride_nxt = stride_r;
    if (ctl.clear) begin
      idx_nxt    = '0;
      stride_nxt = '0;
    end else begin
      if (ctl.stride_add) begin
        stride_nxt = stride_r + ctl.coef;
      end
      // advance on carry, drop back to zero on wrap
      if (step && active && carry_in) begin
        idx_nxt = wrap ? '0 : idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      stride_r <= '0;
    end else begin
      idx_r    <= idx_nxt;
      stride_r <= stride_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.back_calc) begin
      back_r <= back_prod[ADDR_W-1:0];
    end
    if (ctl.delta_load) begin
      delta_r <= stride_r - ctl.acc;
    end
  end

endmodule

FILE: sv/tpag_deriver.sv
// ----------------------------------------------------------------------------
// tpag_deriver
// Sequencer that derives strides and address steps into the cells.
// ----------------------------------------------------------------------------
module tpag_deriver #(
  parameter int NCELL    = tpag_pkg::NUM_DIMS,
  parameter int DIM_BITS = tpag_pkg::DIM_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [tpag_pkg::PERM_W-1:0]   perm_code,
  input  logic [tpag_pkg::RANK_W-1:0]   rank_eff,
  input  logic [DIM_BITS-1:0]           size_top [NCELL],
  input  tpag_pkg::addr_t               backs    [NCELL],
  output tpag_pkg::cell_ctl_t           ctl      [NCELL],
  output logic                          busy
);
  import tpag_pkg::*;

  localparam int CELL_W = (NCELL > 1) ? $clog2(NCELL) : 1;

  seq_state_t               state_r, state_nxt;
  logic [CELL_W-1:0]        pos_r, pos_nxt;
  addr_t                    coef_r, coef_nxt;
  addr_t                    acc_r, acc_nxt;
  logic [PERM_FIELD_W-1:0]  p;
  logic                     p_ok;
  logic [CELL_W-1:0]        pidx;
  logic [DIM_BITS:0]        size_eff;
  logic [ADDR_W+DIM_BITS:0] coef_prod;

  assign p         = perm_code[PERM_FIELD_W*pos_r +: PERM_FIELD_W];
  assign p_ok      = (p < rank_eff);
  assign pidx      = p[CELL_W-1:0];
  assign size_eff  = {1'b0, size_top[pidx]} + 1'b1;
  assign coef_prod = coef_r * size_eff;
  assign busy      = (state_r != SEQ_IDLE);

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    coef_nxt  = coef_r;
    acc_nxt   = acc_r;
    for (int c = 0; c < NCELL; c++) begin
      ctl[c].clear      = 1'b0;
      ctl[c].stride_add = 1'b0;
      ctl[c].back_calc  = 1'b0;
      ctl[c].delta_load = 1'b0;
      ctl[c].coef       = coef_r;
      ctl[c].acc        = acc_r;
    end
    unique case (state_r)
      SEQ_IDLE: begin
      end
      SEQ_START: begin
        for (int c = 0; c < NCELL; c++) ctl[c].clear = 1'b1;
        pos_nxt   = CELL_W'(rank_eff - 1'b1);
        coef_nxt  = addr_t'(1);
        state_nxt = SEQ_STRIDE;
      end
      SEQ_STRIDE: begin
        // walk destination positions from innermost outward
        if (p_ok) begin
          for (int c = 0; c < NCELL; c++) begin
            if (32'(pidx) == c) ctl[c].stride_add = 1'b1;
          end
          coef_nxt = coef_prod[ADDR_W-1:0];
        end
        if (pos_r == '0) begin
          state_nxt = SEQ_BACK;
        end else begin
          pos_nxt = pos_r - 1'b1;
        end
      end
      SEQ_BACK: begin
        for (int c = 0; c < NCELL; c++) ctl[c].back_calc = 1'b1;
        pos_nxt   = CELL_W'(NCELL - 1);
        acc_nxt   = '0;
        state_nxt = SEQ_DELTA;
      end
      SEQ_DELTA: begin
        // suffix sum of wrap-back amounts, innermost cell first
        for (int c = 0; c < NCELL; c++) begin
          if (32'(pos_r) == c) ctl[c].delta_load = 1'b1;
        end
        acc_nxt = acc_r + backs[pos_r];
        if (pos_r == '0) begin
          state_nxt = SEQ_IDLE;
        end else begin
          pos_nxt = pos_r - 1'b1;
        end
      end
      default: state_nxt = SEQ_IDLE;
    endcase
    if (start) begin
      state_nxt = SEQ_START;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_START;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r  <= pos_nxt;
    coef_r <= coef_nxt;
    acc_r  <= acc_nxt;
  end

endmodule

FILE: sv/tpag_out_skid.sv
// ----------------------------------------------------------------------------
// tpag_out_skid
// Output register plus skid stage for the result stream.
// ----------------------------------------------------------------------------
module tpag_out_skid #(
  parameter int ELEMENT_BITS = tpag_pkg::ELEMENT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             push,
  input  tpag_pkg::addr_t                  push_addr,
  input  logic [ELEMENT_BITS-1:0]          push_elem,
  input  logic                             push_last,
  output logic                             full,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [tpag_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                             out_tlast
);
  import tpag_pkg::*;

  localparam int PW = ADDR_W + ELEMENT_BITS + 1;

  logic          out_valid_r, out_valid_nxt;
  logic          skid_valid_r, skid_valid_nxt;
  logic [PW-1:0] out_data_r, out_data_nxt;
  logic [PW-1:0] skid_data_r, skid_data_nxt;
  logic [PW-1:0] push_data;
  logic          take;

  assign push_data = {push_last, push_elem, push_addr};
  assign take      = out_valid_r & out_tready;
  assign full      = skid_valid_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (take) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || take) begin
        out_data_nxt  = push_data;
        out_valid_nxt = 1'b1;
      end else begin
        skid_data_nxt  = push_data;
        skid_valid_nxt = 1'b1;
      end
    end else if (take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_data_r[PW-1];
  assign out_tdata  = OUT_TDATA_W'({ELEM_FIELD_W'(out_data_r[PW-2:ADDR_W]),
                                    out_data_r[ADDR_W-1:0]});

endmodule

FILE: sv/tensor_permute_address_generator.sv
// ----------------------------------------------------------------------------
// tensor_permute_address_generator
// Destination addresses for a dimension-permuted (transposed) tensor stream.
// ----------------------------------------------------------------------------
//
//  channel  direction  payload                                  end of run
//  in_      slave      element_in                                -
//  out_     master     dest_address, element_out                tlast
//  cfg_     write      rank, perm_code, size_dim0..size_dim5    -
//
// One element per cycle while in_tready is high: the odometer carry ripples
// through a row of cells, one per source dimension, and a single 60-bit add
// moves the address. After reset and after every register write the stride
// sequencer runs, one multiply per destination position; in_tready stays low
// meanwhile.
// rst_n is synchronous; it clears counters, address and the output stage.
// An output stall holds the result; a second element parks in the skid stage.
// ----------------------------------------------------------------------------
module tensor_permute_address_generator #(
  parameter int MAX_RANK     = tpag_pkg::MAX_RANK_DEF,
  parameter int DIM_BITS     = tpag_pkg::DIM_BITS_DEF,
  parameter int ELEMENT_BITS = tpag_pkg::ELEMENT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata: [63:0] element_in
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [tpag_pkg::IN_TDATA_W-1:0]   in_tdata,
  // out_tdata: [59:0] dest_address, [123:60] element_out, [127:124] zero
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [tpag_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                              out_tlast,
  input  logic                              cfg_we,
  input  logic [tpag_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tpag_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import tpag_pkg::*;

  // cells beyond the sixth dimension never take part
  localparam int NCELL = (MAX_RANK < NUM_DIMS) ? MAX_RANK : NUM_DIMS;

  // Configuration registers
  logic [RANK_W-1:0] rank_r;
  logic [PERM_W-1:0] perm_r;
  logic [SIZE_W-1:0] size_r [NCELL];
  logic [RANK_W-1:0] rank_eff;
  logic [DIM_BITS-1:0] size_top [NCELL];

  // Cell row
  cell_ctl_t ctl   [NCELL];
  addr_t     backs [NCELL];
  addr_t     delta [NCELL];
  logic      carry_in  [NCELL];
  logic      carry_out [NCELL];
  logic      hit       [NCELL];

  logic  busy;
  logic  skid_full;
  logic  in_accept;
  logic  last_now;
  addr_t step_sel;
  addr_t run_addr_r, run_addr_nxt;

  // ---------------------------------------------------------------------------
  // Configuration port: any write restarts the tensor and re-derives strides
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_r <= RESET_RANK;
      perm_r <= RESET_PERM;
      for (int c = 0; c < NCELL; c++) size_r[c] <= RESET_SIZE;
    end else if (cfg_we) begin
      priority if (cfg_index == CFG_RANK) begin
        rank_r <= cfg_wdata[RANK_W-1:0];
      end else if (cfg_index == CFG_PERM) begin
        perm_r <= cfg_wdata[PERM_W-1:0];
      end else begin
        for (int c = 0; c < NCELL; c++) begin
          if (32'(cfg_index) == 32'(CFG_SIZE0) + c) size_r[c] <= cfg_wdata[SIZE_W-1:0];
        end
      end
    end
  end

  // Clamp rank to 1..NCELL
  always_comb begin
    if (rank_r == '0) begin
      rank_eff = RANK_W'(1);
    end else if (32'(rank_r) > NCELL) begin
      rank_eff = RANK_W'(NCELL);
    end else begin
      rank_eff = rank_r;
    end
  end

  // Highest index per dimension: size clamped to 1..2^DIM_BITS, minus one
  always_comb begin
    for (int c = 0; c < NCELL; c++) begin
      if (size_r[c] == '0) begin
        size_top[c] = '0;
      end else if (32'(size_r[c]) > (32'd1 << DIM_BITS)) begin
        size_top[c] = '1;
      end else begin
        size_top[c] = DIM_BITS'(32'(size_r[c]) - 32'd1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stride sequencer
  // ---------------------------------------------------------------------------
  tpag_deriver #(
    .NCELL    (NCELL),
    .DIM_BITS (DIM_BITS)
  ) u_deriver (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cfg_we),
    .perm_code (perm_r),
    .rank_eff  (rank_eff),
    .size_top  (size_top),
    .backs     (backs),
    .ctl       (ctl),
    .busy      (busy)
  );

  // ---------------------------------------------------------------------------
  // Cell row: carry enters at the innermost cell and ripples outward
  // ---------------------------------------------------------------------------
  for (genvar c = 0; c < NCELL; c++) begin : g_cell
    if (c == NCELL - 1) begin : g_inner
      assign carry_in[c] = 1'b1;
    end else begin : g_outer
      assign carry_in[c] = carry_out[c+1];
    end

    tpag_cell #(
      .DIM_BITS (DIM_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl[c]),
      .top_idx   (size_top[c]),
      .active    (32'(rank_eff) > c),
      .carry_in  (carry_in[c]),
      .step      (in_accept),
      .back      (backs[c]),
      .delta     (delta[c]),
      .carry_out (carry_out[c]),
      .hit       (hit[c])
    );
  end

  // every active counter at its top: this is the final element
  assign last_now = carry_out[0];

  // the cell that absorbs the carry supplies the address step
  always_comb begin
    step_sel = '0;
    for (int c = 0; c < NCELL; c++) begin
      if (hit[c]) step_sel = step_sel | delta[c];
    end
  end

  // hold off input during a register write, during derivation and while the skid stage is occupied
  assign in_tready = ~busy & ~cfg_we & ~skid_full;
  assign in_accept = in_tvalid & in_tready;

  // ---------------------------------------------------------------------------
  // Running destination address
  // ---------------------------------------------------------------------------
  always_comb begin
    run_addr_nxt = run_addr_r;
    if (ctl[0].clear) begin
      run_addr_nxt = '0;
    end else if (in_accept) begin
      run_addr_nxt = last_now ? '0 : run_addr_r + step_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_addr_r <= '0;
    end else begin
      run_addr_r <= run_addr_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register and skid stage
  // ---------------------------------------------------------------------------
  tpag_out_skid #(
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_accept),
    .push_addr  (run_addr_r),
    .push_elem  (in_tdata[ELEMENT_BITS-1:0]),
    .push_last  (last_now),
    .full       (skid_full),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: sv/tpag_checker.sv
// ----------------------------------------------------------------------------
// tpag_checker
// Port-level checks on the tensor permute address generator.
// ----------------------------------------------------------------------------
`include "tensor_permute_address_generator_macros.svh"

module tpag_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [tpag_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic                              out_tlast,
  input logic                              cfg_we
);
  import tpag_pkg::*;

  logic                                    out_stall;
  logic [OUT_TDATA_W:0]                    out_beat;
  logic [OUT_TDATA_W-ADDR_W-ELEM_FIELD_W-1:0] out_pad;

  assign out_stall = out_tvalid && !out_tready;
  assign out_beat  = {out_tlast, out_tdata};
  assign out_pad   = out_tdata[OUT_TDATA_W-1:ADDR_W+ELEM_FIELD_W];

  // a stalled result holds
  `TPAG_ASSERT_NEXT(a_out_hold, out_stall, out_tvalid && $stable(out_beat), "stalled result changed")

  // no transfer in the cycle of a register write
  `TPAG_ASSERT_NOW(a_cfg_block, cfg_we, !in_tready, "input ready during register write")

  // stride derivation keeps the input closed after a write
  `TPAG_ASSERT_NEXT(a_cfg_busy, cfg_we, !in_tready, "input ready after register write")

  // padding bits above element_out stay zero
  `TPAG_ASSERT_NOW(a_pad_zero, out_tvalid, out_pad == '0, "nonzero padding in result")

endmodule

bind tensor_permute_address_generator tpag_checker u_tpag_checker (.*);

FILE: dv/tensor_permute_address_generator_test.sv
// ----------------------------------------------------------------------------
// Tensor permute address generator test
// Streams source-order elements through the address generator across many
// shapes, permutations and register settings, predicts each destination
// address, pass-through word and end-of-tensor flag, and compares every
// output transfer against the prediction under random source and sink stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tensor_permute_address_generator_test;

  import tpag_pkg::*;

  localparam int QUIET_LIMIT  = 4000;  // cycles without any transfer
  localparam int RANDOM_ITEMS = 1400;
  localparam int REPORT_MAX   = 10;

  // One predicted output transfer.
  typedef struct {
    addr_t       addr;
    logic [63:0] word;
    logic        last;
  } placement_t;

  // Shadow of the register file and the odometer. Registers are applied as
  // they are written; every write recomputes the strides and restarts the
  // tensor, just like the hardware.
  class permute_tracker;
    logic [RANK_W-1:0] rank_reg;
    logic [PERM_W-1:0] perm_reg;
    logic [SIZE_W-1:0] extent_reg [NUM_DIMS];
    logic [9:0]        index [NUM_DIMS];
    addr_t             cursor;
    addr_t             stride [NUM_DIMS];
    placement_t        placements_due [$];
    int                mismatches;

    function new();
      rank_reg = RESET_RANK;
      perm_reg = RESET_PERM;
      foreach (extent_reg[d]) extent_reg[d] = RESET_SIZE;
      mismatches = 0;
      restart();
    endfunction

    // Rank 0 counts as 1, anything above six as six.
    function int live_rank();
      if (rank_reg == 0) return 1;
      return (rank_reg > NUM_DIMS) ? NUM_DIMS : int'(rank_reg);
    endfunction

    // Extent 0 counts as 1, anything above 1024 as 1024.
    function int live_extent(int d);
      if (extent_reg[d] == 0) return 1;
      return (extent_reg[d] > 1024) ? 1024 : int'(extent_reg[d]);
    endfunction

    // Walk destination positions innermost first; a field naming a dimension
    // outside the rank adds nothing, a repeated one accumulates strides.
    function void restart();
      int    r;
      int    p;
      addr_t coef;
      r    = live_rank();
      coef = 1;
      for (int d = 0; d < NUM_DIMS; d++) begin
        stride[d] = '0;
        index[d]  = '0;
      end
      for (int i = r - 1; i >= 0; i--) begin
        p = perm_reg[PERM_FIELD_W*i +: PERM_FIELD_W];
        if (p < r) begin
          stride[p] = stride[p] + coef;
          coef      = coef * addr_t'(live_extent(p));
        end
      end
      cursor = '0;
    endfunction

    function void apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      if (idx == CFG_RANK) rank_reg = value[RANK_W-1:0];
      else if (idx == CFG_PERM) perm_reg = value[PERM_W-1:0];
      else extent_reg[idx - CFG_SIZE0] = value[SIZE_W-1:0];
      restart();
    endfunction

    function void note_element(logic [63:0] word);
      int         r;
      placement_t e;
      r      = live_rank();
      e.addr = cursor;
      e.word = word;
      e.last = 1'b1;
      for (int d = 0; d < r; d++)
        if (index[d] != live_extent(d) - 1) e.last = 1'b0;
      placements_due.push_back(e);
      // Odometer step: wrap the inner dimensions, bump the first that has room.
      for (int d = r - 1; d >= 0; d--) begin
        if (index[d] >= live_extent(d) - 1) begin
          cursor   = cursor - addr_t'(index[d]) * stride[d];
          index[d] = '0;
        end else begin
          index[d] = index[d] + 1'b1;
          cursor   = cursor + stride[d];
          break;
        end
      end
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= REPORT_MAX) $display("%s", msg);
    endfunction

    function void check_transfer(addr_t addr, logic [63:0] word, logic last);
      placement_t e;
      if (placements_due.size() == 0) begin
        report($sformatf("unexpected transfer: dest_address %h element_out %h last %b",
                         addr, word, last));
        return;
      end
      e = placements_due.pop_front();
      if (addr !== e.addr)
        report($sformatf("dest_address: expected %h, got %h", e.addr, addr));
      if (word !== e.word)
        report($sformatf("element_out: expected %h, got %h", e.word, word));
      if (last !== e.last)
        report($sformatf("last_element: expected %b, got %b (dest_address %h)",
                         e.last, last, e.addr));
    endfunction
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    in_tvalid;
  logic                    in_tready;
  logic [IN_TDATA_W-1:0]   in_tdata;
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  out_tdata;
  logic                    out_tlast;
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_wdata;

  permute_tracker book = new();

  int send_idle_pct  = 0;   // chance per cycle that the source holds off
  int sink_stall_pct = 0;   // chance per cycle that the sink drops tready
  int elements_sent  = 0;
  int quiet_cycles   = 0;

  tensor_permute_address_generator i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Sink: pick tready on the falling edge so it is stable at the next rise.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Check every output transfer: dest_address low, element_out above it.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      book.check_transfer(out_tdata[ADDR_W-1:0], out_tdata[ADDR_W +: ELEM_FIELD_W], out_tlast);
  end

  // Count cycles in which neither channel moves a transfer.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  // Watchdog: a hung block ends the run here.
  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Offer one element; hold it until the transfer, then leave tvalid high so
  // the next call can keep streaming without a gap.
  task automatic push_element(input logic [63:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
    book.note_element(word);
    elements_sent++;
    @(negedge clk);
  endtask

  // Drop tvalid and hold off until every predicted transfer has come out.
  // Each element yields exactly one result, so the block is idle afterwards.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (book.placements_due.size() != 0) @(negedge clk);
  endtask

  // One register write; the caller lowers cfg_we after the last one.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    book.apply_register(idx, value);
  endtask

  task automatic load_registers(input int rank_v, input logic [PERM_W-1:0] perm_v,
                                input int ext [NUM_DIMS]);
    write_reg(CFG_RANK, CFG_DATA_W'(rank_v));
    write_reg(CFG_PERM, CFG_DATA_W'(perm_v));
    for (int d = 0; d < NUM_DIMS; d++)
      write_reg(CFG_SIZE0 + CFG_IDX_W'(d), CFG_DATA_W'(ext[d]));
    cfg_we <= 1'b0;
  endtask

  function automatic logic [PERM_W-1:0] pack_perm(input int fields [NUM_DIMS]);
    logic [PERM_W-1:0] code;
    code = '0;
    for (int i = 0; i < NUM_DIMS; i++)
      code[PERM_FIELD_W*i +: PERM_FIELD_W] = PERM_FIELD_W'(fields[i]);
    return code;
  endfunction

  // One random setting followed by a burst of elements. Most settings are
  // well-formed small tensors streamed whole (often twice, sometimes with a
  // partial tail); the rest scramble the permutation or push extents and
  // rank outside their range.
  task automatic random_round();
    int kind;
    int rank_v;
    int r;
    int total;
    int count;
    int j;
    int tmp;
    int fields [NUM_DIMS];
    int ext [NUM_DIMS];
    kind   = $urandom_range(99);
    rank_v = (kind < 70) ? $urandom_range(1, NUM_DIMS) : $urandom_range(0, 7);
    r      = (rank_v == 0) ? 1 : ((rank_v > NUM_DIMS) ? NUM_DIMS : rank_v);

    // Shuffle a proper permutation over the live dimensions.
    for (int i = 0; i < NUM_DIMS; i++) fields[i] = i;
    for (int i = r - 1; i > 0; i--) begin
      j         = $urandom_range(i);
      tmp       = fields[i];
      fields[i] = fields[j];
      fields[j] = tmp;
    end
    for (int i = r; i < NUM_DIMS; i++) fields[i] = $urandom_range(7);
    if (kind >= 70 && kind < 85) begin
      for (int i = 0; i < NUM_DIMS; i++) fields[i] = $urandom_range(7);
    end else if (kind >= 85 && $urandom_range(1)) begin
      // Repeat dimensions so strides pile up on one counter.
      for (int i = 0; i < r; i++) fields[i] = $urandom_range(r - 1);
    end

    total = 1;
    for (int d = 0; d < NUM_DIMS; d++) begin
      if (d >= r) begin
        ext[d] = $urandom_range(2047);
      end else if (kind >= 85) begin
        case ($urandom_range(7))
          0: ext[d] = 0;
          1: ext[d] = 1;
          2: ext[d] = 2;
          3: ext[d] = 1023;
          4: ext[d] = 1024;
          5: ext[d] = 1025;
          6: ext[d] = 2047;
          default: ext[d] = $urandom_range(3, 2047);
        endcase
      end else begin
        ext[d] = $urandom_range(1, (r <= 3) ? 6 : ((r == 4) ? 4 : 3));
        total  = total * ext[d];
      end
    end

    if (kind >= 85) begin
      count = $urandom_range(8, 48);
    end else begin
      count = total * $urandom_range(1, 2);
      if ($urandom_range(1)) count = count + $urandom_range(0, total - 1);
      if (count > 240) count = 240;
    end

    settle();
    load_registers(rank_v, pack_perm(fields), ext);
    repeat (count) push_element({$urandom(), $urandom()});
  endtask

  initial begin
    int fields [NUM_DIMS];
    int ext [NUM_DIMS];
    int phase;
    int directed_count;

    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset shape is a single element: every transfer is last, address 0.
    push_element('0);
    push_element('1);

    // 3x2 transpose, streamed whole and then into a second copy.
    fields = '{1, 0, 2, 3, 4, 5};
    ext    = '{3, 2, 1, 1, 1, 1};
    settle();
    load_registers(2, pack_perm(fields), ext);
    repeat (8) push_element({$urandom(), $urandom()});

    // Rewrite one register mid-tensor: counters must restart from zero.
    settle();
    write_reg(CFG_SIZE0 + CFG_IDX_W'(1), CFG_DATA_W'(2));
    cfg_we <= 1'b0;
    repeat (2) push_element({$urandom(), $urandom()});

    // Rank above six, reversed order, zero and oversized extents.
    fields = '{5, 4, 3, 2, 1, 0};
    ext    = '{2, 0, 2047, 1, 2, 1};
    settle();
    load_registers(7, pack_perm(fields), ext);
    repeat (4) push_element({$urandom(), $urandom()});

    // Rank zero behaves as rank one.
    fields = '{0, 1, 2, 3, 4, 5};
    ext    = '{2, 5, 5, 5, 5, 5};
    settle();
    load_registers(0, pack_perm(fields), ext);
    repeat (3) push_element({$urandom(), $urandom()});

    // Broken permutation: an out-of-rank field, a repeat, a missing dimension.
    fields = '{7, 1, 1, 0, 0, 0};
    ext    = '{2, 2, 2, 1, 1, 1};
    settle();
    load_registers(3, pack_perm(fields), ext);
    repeat (3) push_element({$urandom(), $urandom()});

    // Full-size rank 6 with one dimension named six times: the strides of all
    // six destination positions pile up on that one dimension's counter.
    fields = '{5, 5, 5, 5, 5, 5};
    ext    = '{1024, 1024, 1024, 1024, 1024, 1024};
    settle();
    load_registers(6, pack_perm(fields), ext);
    repeat (3) push_element({$urandom(), $urandom()});

    // Random part in four idling phases: none, source, sink, both.
    directed_count = elements_sent;
    while (elements_sent < directed_count + RANDOM_ITEMS) begin
      phase = (elements_sent - directed_count) * 4 / RANDOM_ITEMS;
      case (phase)
        0:       begin send_idle_pct = 0;  sink_stall_pct = 0;  end
        1:       begin send_idle_pct = 73; sink_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  sink_stall_pct = 73; end
        default: begin send_idle_pct = 31; sink_stall_pct = 31; end
      endcase
      random_round();
    end

    // Drain, then give the pipeline time to show any stray transfer.
    settle();
    repeat (24) @(posedge clk);
    if (book.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
